/* design/ascs_pkg.sv */
// Shared types, constants and per-byte functions of the sentence checker.
package ascs_pkg;

  localparam int unsigned MAX_LINE   = 1024;
  localparam int unsigned LINE_LEN_W = $clog2(MAX_LINE + 1);

  localparam int unsigned CFG_INDEX_W = 2;
  localparam int unsigned CFG_DATA_W  = 6;

  localparam logic [CFG_INDEX_W-1:0] CFG_FIRST_FIELD = 2'd0;
  localparam logic [CFG_INDEX_W-1:0] CFG_LAST_FIELD  = 2'd1;
  localparam logic [CFG_INDEX_W-1:0] CFG_MIN_FIELDS  = 2'd2;

  localparam logic [3:0] FIRST_FIELD_RESET = 4'd5;
  localparam logic [3:0] LAST_FIELD_RESET  = 4'd10;
  localparam logic [5:0] MIN_FIELDS_RESET  = 6'd11;

  localparam logic [7:0] CHAR_NEWLINE = 8'h0A;
  localparam logic [7:0] CHAR_STAR    = 8'h2A;
  localparam logic [7:0] CHAR_COMMA   = 8'h2C;

  localparam logic [2:0] HDR_LEN = 3'd6;
  localparam logic [5:0] COMMA_MAX = 6'd63;
  localparam logic [5:0] FIELD_MAX = 6'd15;
  localparam logic [2:0] HEX_CNT_MAX = 3'd7;

  typedef enum logic [1:0] {
    PH_HEADER,
    PH_BODY,
    PH_HEX,
    PH_SKIP
  } phase_t;

  typedef enum logic [2:0] {
    V_OK         = 3'd0,
    V_MISMATCH   = 3'd1,
    V_FEW_FIELDS = 3'd2,
    V_NO_DIGITS  = 3'd3,
    V_OVERLONG   = 3'd4
  } verdict_t;

  typedef struct packed {
    logic [3:0] first_field;
    logic [3:0] last_field;
    logic [5:0] min_fields;
  } cfg_t;

  typedef struct packed {
    logic        is_verdict;
    logic [3:0]  field_number;
    logic [7:0]  payload_byte;
    logic [2:0]  verdict;
    logic [15:0] received_check;
    logic [15:0] computed_check;
  } result_t;

  // Expected header byte at a given position of the line.
  function automatic logic [7:0] hdr_byte(input logic [2:0] pos);
    logic [7:0] b;
    unique case (pos)
      3'd0:    b = 8'h24;
      3'd1:    b = 8'h56;
      3'd2:    b = 8'h4E;
      3'd3:    b = 8'h52;
      3'd4:    b = 8'h52;
      3'd5:    b = 8'h47;
      default: b = 8'h00;
    endcase
    return b;
  endfunction

  // Byte-wise CRC-16, polynomial 0x1021.
  function automatic logic [15:0] crc_step(input logic [15:0] crc, input logic [7:0] b);
    logic [15:0] c;
    c = {crc[7:0], crc[15:8]};
    c = c ^ {8'h00, b};
    c = c ^ {12'h000, c[7:4]};
    c = c ^ {c[3:0], 12'h000};
    c = c ^ {3'b000, c[7:0], 5'b00000};
    return c;
  endfunction

  // Hex digit decode: bit 4 flags a valid digit, bits 3:0 hold its value.
  function automatic logic [4:0] hex_decode(input logic [7:0] b);
    logic [4:0] r;
    r = 5'd0;
    if (b >= 8'h30 && b <= 8'h39) begin
      r = {1'b1, 4'(b - 8'h30)};
    end else if (b >= 8'h41 && b <= 8'h46) begin
      r = {1'b1, 4'(b - 8'h37)};
    end else if (b >= 8'h61 && b <= 8'h66) begin
      r = {1'b1, 4'(b - 8'h57)};
    end
    return r;
  endfunction

endpackage

/* design/ascs_ifs.sv */
// Stream interfaces for received bytes and for result beats.
interface ascs_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] rx_byte;

  modport source (output valid, output rx_byte, input ready);
  modport sink   (input valid, input rx_byte, output ready);
endinterface

interface ascs_out_if;
  logic        valid;
  logic        ready;
  logic        is_verdict;
  logic [3:0]  field_number;
  logic [7:0]  payload_byte;
  logic [2:0]  verdict;
  logic [15:0] received_check;
  logic [15:0] computed_check;

  modport source (output valid, output is_verdict, output field_number,
                  output payload_byte, output verdict, output received_check,
                  output computed_check, input ready);
  modport sink   (input valid, input is_verdict, input field_number,
                  input payload_byte, input verdict, input received_check,
                  input computed_check, output ready);
endinterface

/* design/ascii_sentence_crc16_checker.sv */
// Top level of the ASCII sentence CRC-16 checker.
//
// in_ch  : one received serial byte per beat (valid/ready).
// out_ch : result beats. With is_verdict low a beat carries one payload byte of a
//          forwarded field and its field number; with is_verdict high it closes a
//          "$VNRRG" line that had a '*', with the verdict code, the checksum parsed
//          after the star and the CRC-16 computed over the bytes between '$' and '*'.
// cfg_*  : write port for the forwarded field range and the minimum field count;
//          write only while no beats are in flight.
// Timing: one byte per cycle while the output register is empty or being drained.
// The result beat is presented right after the edge that accepts its byte; the
// whole per-byte step (CRC update, header match, hex decode, verdict select) sits
// between the parse state and that register. Bytes that produce no result leave
// no beat behind.
// Stall: when the receiver holds out_ch.ready low with a beat waiting, in_ch.ready
// drops and the input holds until the beat is taken.
// Reset: synchronous on rst_n; the parser returns to header matching with a
// cleared line, the output register empties and the registers take their
// default range 5..10 and minimum of 11 fields.
module ascii_sentence_crc16_checker (
  input  logic                             clk,
  input  logic                             rst_n,
  ascs_in_if.sink                          in_ch,
  ascs_out_if.source                       out_ch,
  input  logic                             cfg_we,
  input  logic [ascs_pkg::CFG_INDEX_W-1:0] cfg_index,
  input  logic [ascs_pkg::CFG_DATA_W-1:0]  cfg_wdata
);

  ascs_pkg::cfg_t    cfg;
  ascs_pkg::result_t res;
  logic              res_valid;
  logic              can_take;
  logic              accept;

  // Accept a byte whenever the output register has room for its result.
  assign in_ch.ready = can_take;
  assign accept      = in_ch.valid && can_take;

  ascs_cfg_regs u_cfg (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_wdata (cfg_wdata),
    .cfg       (cfg)
  );

  ascs_line_parser u_parser (
    .clk       (clk),
    .rst_n     (rst_n),
    .accept    (accept),
    .rx_byte   (in_ch.rx_byte),
    .cfg       (cfg),
    .res_valid (res_valid),
    .res       (res)
  );

  // Load the output register only for bytes that yield a beat.
  ascs_out_reg u_out (
    .clk      (clk),
    .rst_n    (rst_n),
    .load     (accept && res_valid),
    .res      (res),
    .can_take (can_take),
    .out_ch   (out_ch)
  );

endmodule

/* design/ascs_cfg_regs.sv */
// Configuration registers of the sentence checker.
module ascs_cfg_regs (
  input  logic                             clk,
  input  logic                             rst_n,
  input  logic                             cfg_we,
  input  logic [ascs_pkg::CFG_INDEX_W-1:0] cfg_index,
  input  logic [ascs_pkg::CFG_DATA_W-1:0]  cfg_wdata,
  output ascs_pkg::cfg_t                   cfg
);

  ascs_pkg::cfg_t cfg_r;
  ascs_pkg::cfg_t cfg_nxt;

  always_comb begin
    cfg_nxt = cfg_r;
    if (cfg_we) begin
      unique case (cfg_index)
        ascs_pkg::CFG_FIRST_FIELD: cfg_nxt.first_field = cfg_wdata[3:0];
        ascs_pkg::CFG_LAST_FIELD:  cfg_nxt.last_field  = cfg_wdata[3:0];
        ascs_pkg::CFG_MIN_FIELDS:  cfg_nxt.min_fields  = cfg_wdata;
        default:                   cfg_nxt = cfg_r;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.first_field <= ascs_pkg::FIRST_FIELD_RESET;
      cfg_r.last_field  <= ascs_pkg::LAST_FIELD_RESET;
      cfg_r.min_fields  <= ascs_pkg::MIN_FIELDS_RESET;
    end else begin
      cfg_r <= cfg_nxt;
    end
  end

  assign cfg = cfg_r;

endmodule

/* design/ascs_line_parser.sv */
// Per-line parse state, CRC and field tracking; forms at most one result per byte.
module ascs_line_parser (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                accept,
  input  logic [7:0]          rx_byte,
  input  ascs_pkg::cfg_t      cfg,
  output logic                res_valid,
  output ascs_pkg::result_t   res
);

  ascs_pkg::phase_t                    phase_r, phase_nxt;
  logic [2:0]                          hdr_pos_r, hdr_pos_nxt;
  logic [15:0]                         crc_r, crc_nxt;
  logic [5:0]                          comma_r, comma_nxt;
  logic [15:0]                         parsed_r, parsed_nxt;
  logic [2:0]                          hex_cnt_r, hex_cnt_nxt;
  logic                                hex_stop_r, hex_stop_nxt;
  logic [ascs_pkg::LINE_LEN_W-1:0]     len_r, len_nxt;

  logic [15:0]       crc_upd;
  logic [4:0]        hex_dec;
  logic              is_nl;
  logic              fwd_ok;
  logic [6:0]        field_cnt;
  ascs_pkg::verdict_t verdict_code;

  assign crc_upd   = ascs_pkg::crc_step(crc_r, rx_byte);
  assign hex_dec   = ascs_pkg::hex_decode(rx_byte);
  assign is_nl     = (rx_byte == ascs_pkg::CHAR_NEWLINE);
  assign field_cnt = {1'b0, comma_r} + 7'd1;
  assign fwd_ok    = (comma_r <= ascs_pkg::FIELD_MAX)
                  && (comma_r >= {2'b00, cfg.first_field})
                  && (comma_r <= {2'b00, cfg.last_field});

  always_comb begin
    priority if (len_r >= ascs_pkg::LINE_LEN_W'(ascs_pkg::MAX_LINE)) begin
      verdict_code = ascs_pkg::V_OVERLONG;
    end else if (field_cnt < {1'b0, cfg.min_fields}) begin
      verdict_code = ascs_pkg::V_FEW_FIELDS;
    end else if (hex_cnt_r == 3'd0) begin
      verdict_code = ascs_pkg::V_NO_DIGITS;
    end else if (parsed_r == crc_r) begin
      verdict_code = ascs_pkg::V_OK;
    end else begin
      verdict_code = ascs_pkg::V_MISMATCH;
    end
  end

  // Next state
  always_comb begin
    phase_nxt    = phase_r;
    hdr_pos_nxt  = hdr_pos_r;
    crc_nxt      = crc_r;
    comma_nxt    = comma_r;
    parsed_nxt   = parsed_r;
    hex_cnt_nxt  = hex_cnt_r;
    hex_stop_nxt = hex_stop_r;
    len_nxt      = len_r;
    if (accept) begin
      if (is_nl) begin
        phase_nxt    = ascs_pkg::PH_HEADER;
        hdr_pos_nxt  = 3'd0;
        crc_nxt      = 16'd0;
        comma_nxt    = 6'd0;
        parsed_nxt   = 16'd0;
        hex_cnt_nxt  = 3'd0;
        hex_stop_nxt = 1'b0;
        len_nxt      = '0;
      end else begin
        if (len_r < ascs_pkg::LINE_LEN_W'(ascs_pkg::MAX_LINE)) begin
          len_nxt = len_r + ascs_pkg::LINE_LEN_W'(1);
        end
        unique case (phase_r)
          ascs_pkg::PH_HEADER: begin
            if (rx_byte == ascs_pkg::hdr_byte(hdr_pos_r)) begin
              if (hdr_pos_r != 3'd0) begin
                crc_nxt = crc_upd;
              end
              hdr_pos_nxt = hdr_pos_r + 3'd1;
              if (hdr_pos_r == ascs_pkg::HDR_LEN - 3'd1) begin
                phase_nxt = ascs_pkg::PH_BODY;
              end
            end else begin
              phase_nxt = ascs_pkg::PH_SKIP;
            end
          end
          ascs_pkg::PH_BODY: begin
            if (rx_byte == ascs_pkg::CHAR_STAR) begin
              phase_nxt = ascs_pkg::PH_HEX;
            end else begin
              crc_nxt = crc_upd;
              if (rx_byte == ascs_pkg::CHAR_COMMA && comma_r < ascs_pkg::COMMA_MAX) begin
                comma_nxt = comma_r + 6'd1;
              end
            end
          end
          ascs_pkg::PH_HEX: begin
            if (!hex_stop_r) begin
              if (!hex_dec[4]) begin
                hex_stop_nxt = 1'b1;
              end else begin
                parsed_nxt = {parsed_r[11:0], hex_dec[3:0]};
                if (hex_cnt_r < ascs_pkg::HEX_CNT_MAX) begin
                  hex_cnt_nxt = hex_cnt_r + 3'd1;
                end
              end
            end
          end
          ascs_pkg::PH_SKIP: begin
            phase_nxt = ascs_pkg::PH_SKIP;
          end
          default: phase_nxt = ascs_pkg::PH_SKIP;
        endcase
      end
    end
  end

  // Result for the byte at the input
  always_comb begin
    res       = '0;
    res_valid = 1'b0;
    if (is_nl) begin
      if (phase_r == ascs_pkg::PH_HEX) begin
        res_valid          = 1'b1;
        res.is_verdict     = 1'b1;
        res.verdict        = verdict_code;
        res.received_check = parsed_r;
        res.computed_check = crc_r;
      end
    end else if (phase_r == ascs_pkg::PH_BODY && rx_byte != ascs_pkg::CHAR_STAR
                 && rx_byte != ascs_pkg::CHAR_COMMA && fwd_ok) begin
      res_valid        = 1'b1;
      res.field_number = comma_r[3:0];
      res.payload_byte = rx_byte;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r    <= ascs_pkg::PH_HEADER;
      hdr_pos_r  <= 3'd0;
      crc_r      <= 16'd0;
      comma_r    <= 6'd0;
      parsed_r   <= 16'd0;
      hex_cnt_r  <= 3'd0;
      hex_stop_r <= 1'b0;
      len_r      <= '0;
    end else begin
      phase_r    <= phase_nxt;
      hdr_pos_r  <= hdr_pos_nxt;
      crc_r      <= crc_nxt;
      comma_r    <= comma_nxt;
      parsed_r   <= parsed_nxt;
      hex_cnt_r  <= hex_cnt_nxt;
      hex_stop_r <= hex_stop_nxt;
      len_r      <= len_nxt;
    end
  end

endmodule

/* design/ascs_out_reg.sv */
// Output register holding one result beat toward the receiver.
module ascs_out_reg (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              load,
  input  ascs_pkg::result_t res,
  output logic              can_take,
  ascs_out_if.source        out_ch
);

  logic              valid_r, valid_nxt;
  ascs_pkg::result_t data_r, data_nxt;

  // The register can take a new beat when empty or draining this cycle.
  assign can_take = !valid_r || out_ch.ready;

  always_comb begin
    valid_nxt = valid_r;
    data_nxt  = data_r;
    if (load) begin
      valid_nxt = 1'b1;
      data_nxt  = res;
    end else if (out_ch.ready) begin
      valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else begin
      valid_r <= valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    data_r <= data_nxt;
  end

  assign out_ch.valid          = valid_r;
  assign out_ch.is_verdict     = data_r.is_verdict;
  assign out_ch.field_number   = data_r.field_number;
  assign out_ch.payload_byte   = data_r.payload_byte;
  assign out_ch.verdict        = data_r.verdict;
  assign out_ch.received_check = data_r.received_check;
  assign out_ch.computed_check = data_r.computed_check;

endmodule
